### rtl/core/bums_pkg.sv
// Shared constants, payload types, state encoding and control bundle of the merge sorter
`default_nettype none
package bums_pkg;

  // Capacity and element width
  localparam int MAX_N      = 64;
  localparam int DATA_WIDTH = 32;

  // Address, count and run-bound widths
  localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CW = $clog2(MAX_N + 1);
  localparam int IW = $clog2(3 * MAX_N + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_res;
  } out_req_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_BLK,
    S_RD,
    S_CMP,
    S_ORD,
    S_OUT
  } state_t;

  // Sequencer outputs towards the datapath and the ports
  typedef struct packed {
    logic          in_ready;
    logic          out_valid;
    logic          out_last;
    logic          we0;
    logic          we1;
    logic          wsel_load;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;
    logic          par;
    logic          left_ex;
    logic          right_ex;
  } ctrl_t;

endpackage
`default_nettype wire

### rtl/core/bottom_up_merge_sorter.sv
// Top level of the bottom-up merge sorter: stores, merge selector and sequencer
// Collects signed values, one request a cycle, until a request marked last
// arrives (values past 64 are dropped, the last one included), then sorts
// the set ascending and stably and returns it as a burst with the final
// value marked last_res. The sort ping-pongs between two 64-entry stores
// with two registered read ports each: a pass of run width 1, 2, 4 and so
// on moves every element once, reading both run heads and then comparing
// and writing for each element, after one bounds step per run pair, and
// ceil(log2 N) passes are made. Each result is read from the store and then
// offered until taken. No new request is taken from the last input until
// the last result leaves.
`default_nettype none
module bottom_up_merge_sorter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bums_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bums_pkg::out_req_t     out_data
);
  import bums_pkg::*;

  ctrl_t ctrl;
  logic  take_right;
  data_t sel;
  data_t wdata;
  data_t rd00, rd01, rd10, rd11;
  data_t left_head, right_head;

  // Sequencer
  bums_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_last    (in_data.last),
    .out_ready  (out_ready),
    .take_right (take_right),
    .ctrl       (ctrl)
  );

  // Write either the incoming value or the merged element
  assign wdata = ctrl.wsel_load ? data_t'(in_data.value) : sel;

  bums_ram #(
    .DEPTH (MAX_N),
    .WIDTH (DATA_WIDTH)
  ) u_ram0 (
    .clk    (clk),
    .we     (ctrl.we0),
    .waddr  (ctrl.waddr),
    .wdata  (wdata),
    .raddr0 (ctrl.raddr0),
    .raddr1 (ctrl.raddr1),
    .rdata0 (rd00),
    .rdata1 (rd01)
  );

  bums_ram #(
    .DEPTH (MAX_N),
    .WIDTH (DATA_WIDTH)
  ) u_ram1 (
    .clk    (clk),
    .we     (ctrl.we1),
    .waddr  (ctrl.waddr),
    .wdata  (wdata),
    .raddr0 (ctrl.raddr0),
    .raddr1 (ctrl.raddr1),
    .rdata0 (rd10),
    .rdata1 (rd11)
  );

  // Read from the current source store
  assign left_head  = ctrl.par ? rd10 : rd00;
  assign right_head = ctrl.par ? rd11 : rd01;

  bums_cmp u_cmp (
    .left_head  (left_head),
    .right_head (right_head),
    .left_ex    (ctrl.left_ex),
    .right_ex   (ctrl.right_ex),
    .take_right (take_right),
    .sel        (sel)
  );

  // Ports; the result comes straight from the registered store read
  assign in_ready              = ctrl.in_ready;
  assign out_valid             = ctrl.out_valid;
  assign out_data.sorted_value = 32'(left_head);
  assign out_data.last_res     = ctrl.out_last;

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result requests active together");

  // A merge writes only one store
  a_one_store: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.we0 && ctrl.we1))
    else $error("both stores written in one cycle");

  // After the final result the block takes requests again
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last_res) |=> in_ready)
    else $error("block not ready after final result");

endmodule
`default_nettype wire

### rtl/core/bums_ram.sv
// Generic store with one write port and two registered read ports
`default_nettype none
module bums_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic      [WIDTH-1:0]                       rdata0,
  output logic      [WIDTH-1:0]                       rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register both reads
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

### rtl/core/bums_cmp.sv
// Merge selector: picks the next element from the heads of the left and right runs
`default_nettype none
module bums_cmp (
  input  wire bums_pkg::data_t left_head,
  input  wire bums_pkg::data_t right_head,
  input  wire logic            left_ex,
  input  wire logic            right_ex,
  output logic                 take_right,
  output bums_pkg::data_t      sel
);
  import bums_pkg::*;

  // Take right when the left run is exhausted or the right head is strictly smaller, so equal keys keep their order
  always_comb begin
    take_right = left_ex | (~right_ex & (right_head < left_head));
    sel        = take_right ? right_head : left_head;
  end

endmodule
`default_nettype wire

### rtl/core/bums_ctrl.sv
// Sequencer: collects the set, steps the merge passes and walks the sorted output
`default_nettype none
module bums_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_last,
  input  wire logic            out_ready,
  input  wire logic            take_right,
  output bums_pkg::ctrl_t      ctrl
);
  import bums_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [IW-1:0] sz_r, sz_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] lend_r, lend_nxt;
  logic [CW-1:0] rend_r, rend_nxt;
  logic          par_r, par_nxt;

  logic          room;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] k_inc;
  logic          last_item;
  logic [IW-1:0] sum1, sum2, sz2;

  assign room      = (count_r < CW'(MAX_N));
  assign count_inc = room ? CW'(count_r + CW'(1)) : count_r;
  assign k_inc     = CW'(k_r + CW'(1));
  assign last_item = (k_inc == n_r);
  assign sum1      = IW'(IW'(k_r) + sz_r);
  assign sum2      = IW'(sum1 + sz_r);
  assign sz2       = IW'(sz_r << 1);

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    sz_nxt    = sz_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    lend_nxt  = lend_r;
    rend_nxt  = rend_r;
    par_nxt   = par_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (in_last) begin
            n_nxt     = count_inc;
            count_nxt = '0;
            k_nxt     = '0;
            par_nxt   = 1'b0;
            sz_nxt    = IW'(1);
            state_nxt = (count_inc == CW'(1)) ? S_ORD : S_BLK;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      S_BLK: begin
        // Clip both runs of this pair to the set size
        lend_nxt  = (sum1 > IW'(n_r)) ? n_r : CW'(sum1);
        rend_nxt  = (sum2 > IW'(n_r)) ? n_r : CW'(sum2);
        i_nxt     = k_r;
        j_nxt     = (sum1 > IW'(n_r)) ? n_r : CW'(sum1);
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        k_nxt = k_inc;
        if (take_right) begin
          j_nxt = CW'(j_r + CW'(1));
        end else begin
          i_nxt = CW'(i_r + CW'(1));
        end
        if (k_inc == rend_r) begin
          if (rend_r == n_r) begin
            // Pass done: swap stores and double the run width
            par_nxt   = ~par_r;
            sz_nxt    = sz2;
            k_nxt     = '0;
            state_nxt = (sz2 >= IW'(n_r)) ? S_ORD : S_BLK;
          end else begin
            state_nxt = S_BLK;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_ORD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_item) begin
            state_nxt = S_LOAD;
          end else begin
            k_nxt     = k_inc;
            state_nxt = S_ORD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // Drive datapath controls and handshakes
  always_comb begin
    ctrl           = '0;
    ctrl.par       = par_r;
    ctrl.left_ex   = (i_r == lend_r);
    ctrl.right_ex  = (j_r == rend_r);
    ctrl.raddr1    = j_r[AW-1:0];
    ctrl.raddr0    = i_r[AW-1:0];
    ctrl.waddr     = k_r[AW-1:0];
    case (state_r)
      S_LOAD: begin
        ctrl.in_ready  = 1'b1;
        ctrl.wsel_load = 1'b1;
        ctrl.waddr     = count_r[AW-1:0];
        ctrl.we0       = in_valid & room;
      end
      S_CMP: begin
        ctrl.we0 = par_r;
        ctrl.we1 = ~par_r;
      end
      S_ORD: begin
        ctrl.raddr0 = k_r[AW-1:0];
      end
      S_OUT: begin
        ctrl.raddr0    = k_r[AW-1:0];
        ctrl.out_valid = 1'b1;
        ctrl.out_last  = last_item;
      end
      default: begin
        ctrl.raddr0 = i_r[AW-1:0];
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      par_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      par_r   <= par_nxt;
    end
  end

  // Indices and run bounds, only read in states that set them first
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    sz_r   <= sz_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    lend_r <= lend_nxt;
    rend_r <= rend_nxt;
  end

endmodule
`default_nettype wire
